@@ rtl/sis_pkg.sv @@
package sis_pkg;

    // Store depth and field widths
    localparam int MAX_ITEMS = 64;
    localparam int KEY_BITS  = 16;
    localparam int TAG_BITS  = 10;

    // One stored entry of the cell chain
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                ins;   // place the broadcast item into the chain
        logic                pop;   // shift the chain toward cell 0 by one
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_cell_ctrl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

@@ rtl/sis_if.sv @@
interface sis_in_if;
    import sis_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] sort_key;
    logic [TAG_BITS-1:0] item_tag;
    logic                last_item;

    modport source (output valid, sort_key, item_tag, last_item, input ready);
    modport sink   (input valid, sort_key, item_tag, last_item, output ready);
endinterface

interface sis_out_if;
    import sis_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                end_of_run;
    logic                overflowed;

    modport source (output valid, out_key, out_tag, end_of_run, overflowed, input ready);
    modport sink   (input valid, out_key, out_tag, end_of_run, overflowed, output ready);
endinterface

@@ rtl/sis_cell.sv @@
module sis_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sis_pkg::t_cell_ctrl i_ctrl,
    input  sis_pkg::t_entry     i_left,
    input  logic                i_left_shift,
    input  sis_pkg::t_entry     i_right,
    output sis_pkg::t_entry     o_entry,
    output logic                o_shift
);
    import sis_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;

    // An empty cell, or one holding a strictly greater key, makes room.
    // Equal keys stay put, which keeps the order stable.
    assign o_shift = !r_valid || (r_key > i_ctrl.key);
    assign o_entry = '{valid: r_valid, key: r_key, tag: r_tag};

    // Next entry: drain from the right, or insert / take from the left
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_ctrl.pop) begin
            n_valid = i_right.valid;
            n_key   = i_right.key;
            n_tag   = i_right.tag;
        end else if (i_ctrl.ins && o_shift) begin
            if (i_left_shift) begin
                n_valid = i_left.valid;
                n_key   = i_left.key;
                n_tag   = i_left.tag;
            end else begin
                n_valid = 1'b1;
                n_key   = i_ctrl.key;
                n_tag   = i_ctrl.tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload carries no reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

endmodule

@@ rtl/stable_insertion_sorter.sv @@
// Insertion: one request per cycle while filling, placed into the cell chain in the cycle
// it is accepted, or dropped and flagged as overflow if the last cell is full. After the
// last request the chain drains, one result per cycle while the consumer takes them.
// Input is not taken while the chain drains; the next set may start right after the final pop.
// Synchronous active-low reset clears cell valid bits, state, overflow flag and output valid;
// stored keys and tags are not cleared.
module stable_insertion_sorter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sis_in_if.sink    i_in,
    sis_out_if.source o_out
);
    import sis_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_drop;
    logic                n_drop;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [TAG_BITS-1:0] r_out_tag;
    logic                r_out_end;
    logic                r_out_ovf;

    t_cell_ctrl          w_ctrl;
    t_entry              w_ent   [MAX_ITEMS];
    logic                w_shift [MAX_ITEMS];
    logic                w_accept;
    logic                w_full;

    // Cell chain
    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
        t_entry w_left;
        logic   w_left_shift;
        t_entry w_right;

        if (gi == 0) begin : g_head
            assign w_left       = '0;
            assign w_left_shift = 1'b0;
        end else begin : g_mid
            assign w_left       = w_ent[gi-1];
            assign w_left_shift = w_shift[gi-1];
        end

        if (gi == MAX_ITEMS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_ent[gi+1];
        end

        sis_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_left       (w_left),
            .i_left_shift (w_left_shift),
            .i_right      (w_right),
            .o_entry      (w_ent[gi]),
            .o_shift      (w_shift[gi])
        );
    end

    assign w_full   = w_ent[MAX_ITEMS-1].valid;
    assign w_accept = i_in.valid && i_in.ready;

    // Sequencer: fill the chain, then drain it into the output register
    always_comb begin
        n_state     = r_state;
        n_drop      = r_drop;
        i_in.ready  = 1'b0;
        w_ctrl.ins  = 1'b0;
        w_ctrl.pop  = 1'b0;
        w_ctrl.key  = i_in.sort_key;
        w_ctrl.tag  = i_in.item_tag;
        unique case (r_state)
            ST_FILL: begin
                i_in.ready = 1'b1;
                if (w_accept) begin
                    w_ctrl.ins = !w_full;
                    if (w_full) begin
                        n_drop = 1'b1;
                    end
                    if (i_in.last_item) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                w_ctrl.pop = !r_out_valid || o_out.ready;
                if (w_ctrl.pop && !w_ent[1].valid) begin
                    n_state = ST_FILL;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drop  <= n_drop;
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctrl.pop) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.pop) begin
            r_out_key <= w_ent[0].key;
            r_out_tag <= w_ent[0].tag;
            r_out_end <= !w_ent[1].valid;
            r_out_ovf <= r_drop;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_key    = r_out_key;
    assign o_out.out_tag    = r_out_tag;
    assign o_out.end_of_run = r_out_end;
    assign o_out.overflowed = r_out_ovf;

    // Chain invariants for the checks below
    logic w_gap;
    logic w_order_err;
    logic w_shift_err;

    always_comb begin
        w_gap       = 1'b0;
        w_order_err = 1'b0;
        w_shift_err = 1'b0;
        for (int i = 0; i < MAX_ITEMS - 1; i++) begin
            w_gap       = w_gap | (w_ent[i+1].valid && !w_ent[i].valid);
            w_order_err = w_order_err | (w_ent[i+1].valid && (w_ent[i].key > w_ent[i+1].key));
            w_shift_err = w_shift_err | (w_shift[i] && !w_shift[i+1]);
        end
    end

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n) !w_gap)
        else $error("valid entries not contiguous from cell 0");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n) !w_order_err)
        else $error("stored keys out of ascending order");

    a_shift_suffix: assert property (@(posedge i_clk) disable iff (!i_rst_n) !w_shift_err)
        else $error("make-room pattern is not a suffix of the chain");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_ent[0].valid)
        else $error("draining with an empty head cell");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.out_key)
            && $stable(o_out.out_tag) && $stable(o_out.end_of_run)
            && $stable(o_out.overflowed)))
        else $error("waiting result changed before it was taken");

endmodule
